FILE: rtl/prime_sum_trial_division_defines.svh
// assertion macros for the prime sum trial division block
`ifndef PRIME_SUM_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_SUM_TRIAL_DIVISION_DEFINES_SVH

`ifndef SYNTH
`define PSUM_ASSERT_NOW(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("psum assertion failed");
`define PSUM_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("psum assertion failed");
`else
`define PSUM_ASSERT_NOW(lbl, clk, rst, cond, prop)
`define PSUM_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif

`endif

FILE: rtl/psum_pkg.sv
// types and microcode step addresses for the prime sum sequencer
`timescale 1ns / 1ps
package psum_pkg;

   localparam int PC_BITS = 4;
   localparam int SUM_BITS = 32;

   typedef logic [PC_BITS-1:0] pc_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_K_GT_N   = 3'd3,
      COND_DSQ_GT_K = 3'd4,
      COND_CNT_NZ   = 3'd5,
      COND_REM_ZERO = 3'd6,
      COND_OUT_FREE = 3'd7
   } cond_type;

   typedef struct packed {
      logic     ld_in;
      logic     d_init;
      logic     d_inc;
      logic     r_init;
      logic     r_step;
      logic     add_k;
      logic     inc_k;
      logic     ld_out;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic k_gt_n;
      logic dsq_gt_k;
      logic cnt_nz;
      logic rem_zero;
      logic out_free;
   } status_type;

   localparam pc_type S_WAIT  = 4'd0;
   localparam pc_type S_KCHK  = 4'd1;
   localparam pc_type S_DINIT = 4'd2;
   localparam pc_type S_DCHK  = 4'd3;
   localparam pc_type S_RINIT = 4'd4;
   localparam pc_type S_RSTEP = 4'd5;
   localparam pc_type S_RTEST = 4'd6;
   localparam pc_type S_DINC  = 4'd7;
   localparam pc_type S_ADDK  = 4'd8;
   localparam pc_type S_NEXTK = 4'd9;
   localparam pc_type S_OUT   = 4'd10;
   localparam pc_type S_HOLD  = 4'd11;

endpackage

FILE: rtl/psum_seq.sv
// microcode store, step counter and jump logic
`timescale 1ns / 1ps
module psum_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  psum_pkg::status_type status,
   output psum_pkg::ctrl_type   ctrl
);

   psum_pkg::pc_type pc_ff;
   psum_pkg::pc_type pc_in;
   logic             take_jump;

   always_comb begin
      ctrl = '0;
      unique case (pc_ff)
         psum_pkg::S_WAIT: begin
            ctrl.ld_in  = 1'b1;
            ctrl.cond   = psum_pkg::COND_NO_REQ;
            ctrl.target = psum_pkg::S_WAIT;
         end
         psum_pkg::S_KCHK: begin
            ctrl.cond   = psum_pkg::COND_K_GT_N;
            ctrl.target = psum_pkg::S_OUT;
         end
         psum_pkg::S_DINIT: begin
            ctrl.d_init = 1'b1;
            ctrl.cond   = psum_pkg::COND_NEVER;
         end
         psum_pkg::S_DCHK: begin
            ctrl.cond   = psum_pkg::COND_DSQ_GT_K;
            ctrl.target = psum_pkg::S_ADDK;
         end
         psum_pkg::S_RINIT: begin
            ctrl.r_init = 1'b1;
            ctrl.cond   = psum_pkg::COND_NEVER;
         end
         psum_pkg::S_RSTEP: begin
            ctrl.r_step = 1'b1;
            ctrl.cond   = psum_pkg::COND_CNT_NZ;
            ctrl.target = psum_pkg::S_RSTEP;
         end
         psum_pkg::S_RTEST: begin
            ctrl.cond   = psum_pkg::COND_REM_ZERO;
            ctrl.target = psum_pkg::S_NEXTK;
         end
         psum_pkg::S_DINC: begin
            ctrl.d_inc  = 1'b1;
            ctrl.cond   = psum_pkg::COND_ALWAYS;
            ctrl.target = psum_pkg::S_DCHK;
         end
         psum_pkg::S_ADDK: begin
            ctrl.add_k  = 1'b1;
            ctrl.cond   = psum_pkg::COND_NEVER;
         end
         psum_pkg::S_NEXTK: begin
            ctrl.inc_k  = 1'b1;
            ctrl.cond   = psum_pkg::COND_ALWAYS;
            ctrl.target = psum_pkg::S_KCHK;
         end
         psum_pkg::S_OUT: begin
            ctrl.ld_out = 1'b1;
            ctrl.cond   = psum_pkg::COND_OUT_FREE;
            ctrl.target = psum_pkg::S_WAIT;
         end
         psum_pkg::S_HOLD: begin
            ctrl.cond   = psum_pkg::COND_ALWAYS;
            ctrl.target = psum_pkg::S_OUT;
         end
         default: begin
            ctrl.cond   = psum_pkg::COND_ALWAYS;
            ctrl.target = psum_pkg::S_WAIT;
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.cond)
         psum_pkg::COND_NEVER:    take_jump = 1'b0;
         psum_pkg::COND_ALWAYS:   take_jump = 1'b1;
         psum_pkg::COND_NO_REQ:   take_jump = !status.req_valid;
         psum_pkg::COND_K_GT_N:   take_jump = status.k_gt_n;
         psum_pkg::COND_DSQ_GT_K: take_jump = status.dsq_gt_k;
         psum_pkg::COND_CNT_NZ:   take_jump = status.cnt_nz;
         psum_pkg::COND_REM_ZERO: take_jump = status.rem_zero;
         psum_pkg::COND_OUT_FREE: take_jump = status.out_free;
         default:                 take_jump = 1'b0;
      endcase
   end

   assign pc_in = take_jump ? ctrl.target : pc_ff + psum_pkg::pc_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= psum_pkg::S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: rtl/psum_dp.sv
// datapath: candidate, divisor, square, restoring remainder and running sum
`timescale 1ns / 1ps
`include "prime_sum_trial_division_defines.svh"
module psum_dp #(
   parameter int LIMIT_BITS = 12,
   parameter int IN_W       = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psum_pkg::ctrl_type             ctrl,
   output psum_pkg::status_type           status,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [IN_W-1:0]                req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [psum_pkg::SUM_BITS-1:0]  rsp_tdata
);

   localparam int K_W   = LIMIT_BITS + 1;
   localparam int SQ_W  = LIMIT_BITS + 2;
   localparam int CNT_W = $clog2(K_W);

   logic [LIMIT_BITS-1:0]         n_ff;
   logic [K_W-1:0]                k_ff;
   logic [K_W-1:0]                d_ff;
   logic [SQ_W-1:0]               dsq_ff;
   logic [K_W-1:0]                rem_ff;
   logic [K_W-1:0]                rem_in;
   logic [CNT_W-1:0]              cnt_ff;
   logic [psum_pkg::SUM_BITS-1:0] sum_ff;
   logic [psum_pkg::SUM_BITS-1:0] out_ff;
   logic                          rsp_tvalid_ff;
   logic [SQ_W-1:0]               trial;
   logic                          load_in;
   logic                          load_out;

   assign req_tready = ctrl.ld_in;
   assign load_in    = ctrl.ld_in & req_tvalid;
   assign load_out   = ctrl.ld_out & status.out_free;

   assign trial  = {rem_ff, k_ff[cnt_ff]};
   assign rem_in = (trial >= {1'b0, d_ff}) ? K_W'(trial - {1'b0, d_ff}) : K_W'(trial);

   always_comb begin
      status.req_valid = req_tvalid;
      status.k_gt_n    = k_ff > {1'b0, n_ff};
      status.dsq_gt_k  = dsq_ff > {1'b0, k_ff};
      status.cnt_nz    = cnt_ff != '0;
      status.rem_zero  = rem_ff == '0;
      status.out_free  = !rsp_tvalid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         n_ff   <= req_tdata[LIMIT_BITS-1:0];
         k_ff   <= K_W'(2);
         sum_ff <= '0;
      end else begin
         if (ctrl.inc_k) begin
            k_ff <= k_ff + K_W'(1);
         end
         if (ctrl.add_k) begin
            sum_ff <= sum_ff + psum_pkg::SUM_BITS'(k_ff);
         end
      end
      if (ctrl.d_init) begin
         d_ff   <= K_W'(2);
         dsq_ff <= SQ_W'(4);
      end else if (ctrl.d_inc) begin
         d_ff   <= d_ff + K_W'(1);
         dsq_ff <= dsq_ff + {d_ff, 1'b1};
      end
      if (ctrl.r_init) begin
         rem_ff <= '0;
         cnt_ff <= CNT_W'(LIMIT_BITS);
      end else if (ctrl.r_step) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (load_out) begin
         out_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = out_ff;

   `PSUM_ASSERT_NOW(a_rem_below_divisor, clock, reset, ctrl.cond == psum_pkg::COND_REM_ZERO, rem_ff < d_ff)
   `PSUM_ASSERT_NOW(a_candidate_from_two, clock, reset, ctrl.cond == psum_pkg::COND_K_GT_N, k_ff >= K_W'(2))
   `PSUM_ASSERT_NEXT(a_sum_cleared_on_load, clock, reset, load_in, sum_ff == '0)
   `PSUM_ASSERT_NEXT(a_result_shown_on_load, clock, reset, load_out, rsp_tvalid && rsp_tdata == $past(sum_ff))

endmodule

FILE: rtl/prime_sum_trial_division.sv
// top level: sum of primes up to a limit by microcoded trial division
//
//   channel  direction  tdata bits (low to high)            tuser/tlast
//   req      in         limit [LIMIT_BITS-1:0], zero pad    none
//   rsp      out        prime_sum [31:0]                    none
//
// each candidate k is checked against the limit, then each divisor d runs the restoring
// remainder loop, one quotient bit per cycle, and a zero-remainder test; d*d <= k bounds d
// one limit is worked at a time; the output register holds a finished sum so the
// next limit is taken while the previous result waits
// reset clears the step counter and the result valid flag; no clearing pass
// a stalled rsp loops the sequencer between its output and hold steps until the register frees
`timescale 1ns / 1ps
module prime_sum_trial_division #(
   parameter int LIMIT_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [((LIMIT_BITS+7)/8)*8-1:0]  req_tdata,   // limit
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [psum_pkg::SUM_BITS-1:0]    rsp_tdata    // prime_sum
);

   localparam int IN_W = ((LIMIT_BITS + 7) / 8) * 8;

   psum_pkg::ctrl_type   ctrl;
   psum_pkg::status_type status;

   psum_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   psum_dp #(
      .LIMIT_BITS (LIMIT_BITS),
      .IN_W       (IN_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/tb_prime_sum_trial_division.sv
// self-checking testbench for the prime sum trial division block
`timescale 1ns / 1ps

class prime_sum_board;
   logic [psum_pkg::SUM_BITS-1:0] expected_sums[$];
   int unsigned errors;
   int unsigned received;

   function new();
      errors = 0;
      received = 0;
   endfunction

   function logic [psum_pkg::SUM_BITS-1:0] sum_primes_upto(logic [11:0] n);
      logic [psum_pkg::SUM_BITS-1:0] total;
      int unsigned k;
      int unsigned d;
      bit no_factor;
      total = '0;
      for (k = 2; k <= n; k++) begin
         no_factor = 1'b1;
         for (d = 2; d * d <= k; d++) begin
            if (k % d == 0) begin
               no_factor = 1'b0;
               break;
            end
         end
         if (no_factor) begin
            total = total + k;
         end
      end
      return total;
   endfunction

   // bits above the limit field are ignored by the block
   function void note_limit(logic [15:0] word);
      expected_sums.push_back(sum_primes_upto(word[11:0]));
   endfunction

   function void check_sum(logic [psum_pkg::SUM_BITS-1:0] got);
      logic [psum_pkg::SUM_BITS-1:0] want;
      received++;
      if (expected_sums.size() == 0) begin
         $display("%0t: prime_sum %0d arrived with none expected", $time, got);
         errors++;
         return;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
         $display("%0t: prime_sum mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_prime_sum_trial_division;
   localparam int LIMIT_W = 12;
   localparam int TDATA_W = ((LIMIT_W + 7) / 8) * 8;
   localparam int PAD_W = TDATA_W - LIMIT_W;
   localparam int IDLE_PCT = 11;
   localparam int HOLD_CYCLES = 3000;
   localparam int HOLD_AT = 2;
   localparam int RANDOM_ITEMS = 88;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [TDATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [psum_pkg::SUM_BITS-1:0] rsp_tdata;

   prime_sum_board board = new();
   bit idle_on = 1'b1;

   prime_sum_trial_division #(
      .LIMIT_BITS(LIMIT_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_limit(input logic [TDATA_W-1:0] word);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      board.note_limit(word);
   endtask

   function automatic logic [TDATA_W-1:0] random_word();
      logic [LIMIT_W-1:0] lim;
      logic [PAD_W-1:0] pad;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 2) begin
         lim = LIMIT_W'($urandom_range(4095, 1024));
      end else if (pick < 17) begin
         lim = LIMIT_W'($urandom_range(511, 128));
      end else begin
         lim = LIMIT_W'($urandom_range(127));
      end
      pad = ($urandom_range(7) == 0) ? PAD_W'($urandom) : '0;
      return {pad, lim};
   endfunction

   // receiver: random stalls plus one long hold-off that backs the block up
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_sum(rsp_tdata);
         end
         if (!held && board.received == HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [TDATA_W-1:0] directed[$];
      int i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd11,
                   16'd12, 16'd13, 16'd100, 16'd101, 16'hF000, 16'hA007, 16'h5001,
                   16'd4095, 16'd1, 16'd0, 16'h300D};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[j]) begin
         send_limit(directed[j]);
      end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on = !(i >= 40 && i < 65);
         send_limit(random_word());
      end
      idle_on = 1'b1;
      req_tvalid <= 1'b0;
      while (board.expected_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.expected_sums.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #300_000_000;
      $display("%0t: timeout", $time);
      $display("*** FAILED ***");
      $finish;
   end
endmodule
